>>> hw/rtl/tbpcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP byte patch checksum fixup - shared definitions
// Constants, types and the one's-complement add helper used by the fixup block.
// ----------------------------------------------------------------------------
package tbpcf_pkg;

   // Bytes of one packet that are parsed, patched and summed.
   localparam int MAX_PACKET_BYTES = 2048;
   localparam int OFFSET_WIDTH     = $clog2(MAX_PACKET_BYTES + 1);

   typedef logic [OFFSET_WIDTH-1:0] offset_type;

   // Configuration register indexes.
   localparam int CSR_ADDR_WIDTH = 2;
   localparam int CSR_DATA_WIDTH = 11;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_PATCH_OFFSET = 2'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_PATCH_VALUE  = 2'd1;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_PATCH_ENABLE = 2'd2;

   // Configuration reset values.
   localparam logic [10:0] PATCH_OFFSET_RESET = 11'd63;
   localparam logic [7:0]  PATCH_VALUE_RESET  = 8'h21;
   localparam logic        PATCH_ENABLE_RESET = 1'b1;

   // Header layout.
   localparam int PROTOCOL_OFFSET    = 9;
   localparam int IP_CSUM_OFFSET_HI  = 10;
   localparam int IP_CSUM_OFFSET_LO  = 11;
   localparam int PSEUDO_ADDR_FIRST  = 12;
   localparam int PSEUDO_ADDR_END    = 20;
   localparam int TCP_DOFF_REL       = 12;
   localparam int TCP_CHECK_REL_HI   = 16;
   localparam int TCP_CHECK_REL_LO   = 17;
   localparam int MIN_HEADER_WORDS   = 5;
   localparam int MIN_PACKET_BYTES   = 10;
   localparam logic [7:0] TCP_PROTOCOL = 8'd6;

   typedef enum logic [1:0] {
      VERDICT_NOT_TCP   = 2'd0,
      VERDICT_TOO_SHORT = 2'd1,
      VERDICT_REWRITTEN = 2'd2,
      VERDICT_MALFORMED = 2'd3
   } verdict_type;

   // One's-complement add with a single end-around fold; the running sum
   // never exceeds 17 bits.
   function automatic logic [16:0] oc_add(input logic [16:0] s, input logic [15:0] v);
      logic [17:0] sum;
      sum    = {1'b0, s} + {2'b00, v};
      oc_add = {1'b0, sum[15:0]} + {15'd0, sum[17:16]};
   endfunction

endpackage

>>> hw/rtl/tcp_byte_patch_checksum_fixup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP byte patch checksum fixup
// Passes an IPv4 packet through one byte per beat, overwrites one configured byte of
// TCP packets, and reports fresh IP and TCP checksums on a rewritten packet's last beat.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Carries
//   req_*     in         req_tvalid/req_tready  packet byte, last flag
//   rsp_*     out        rsp_tvalid/rsp_tready  byte, last, checksums, verdict
//   csr_*     in         csr_valid/csr_ready    register index, write data
//
// One beat is accepted every cycle unless back-pressure fills both stages. A beat
// passes two register stages: the first holds the patched byte, the running sums
// and the verdict, the second holds the folded and inverted checksums. The clock
// period is bounded by the per-byte header parse and the two chained folded adds of
// the TCP sum; the throughput stays at one beat per cycle without back-pressure.
// Synchronous reset clears the pipeline, the per-packet state and loads the
// register defaults. When rsp_tready is low the pipeline keeps filling until
// both stages are full, then req_tready drops. csr_ready is always high.
//
module tcp_byte_patch_checksum_fixup (
   input  logic        clock,
   input  logic        reset,
   // Input stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] pkt_byte
   input  logic        req_tlast,   // pkt_last
   // Result stream.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] out_byte, [23:8] tcp_checksum,
                                    // [39:24] ip_checksum
   output logic        rsp_tlast,   // out_last
   output logic [1:0]  rsp_tuser,   // [1:0] verdict
   // Configuration writes.
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tbpcf_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  logic [tbpcf_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   logic [10:0] patch_offset_ff;
   logic [7:0]  patch_value_ff;
   logic        patch_enable_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         patch_offset_ff <= tbpcf_pkg::PATCH_OFFSET_RESET;
         patch_value_ff  <= tbpcf_pkg::PATCH_VALUE_RESET;
         patch_enable_ff <= tbpcf_pkg::PATCH_ENABLE_RESET;
      end else if (csr_valid) begin
         case (csr_addr)
            tbpcf_pkg::CSR_PATCH_OFFSET: patch_offset_ff <= csr_wdata[10:0];
            tbpcf_pkg::CSR_PATCH_VALUE:  patch_value_ff  <= csr_wdata[7:0];
            tbpcf_pkg::CSR_PATCH_ENABLE: patch_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline handshake. Each stage loads when it is empty or when its
   // contents move on in the same cycle.
   // ------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_load, s1_load, req_fire;

   assign rsp_load   = !rsp_valid_ff || rsp_tready;
   assign s1_load    = !s1_valid_ff || rsp_load;
   assign req_tready = s1_load;
   assign req_fire   = req_tvalid && s1_load;

   always_comb begin
      s1_valid_in  = s1_load ? req_fire : s1_valid_ff;
      rsp_valid_in = rsp_load ? s1_valid_ff : rsp_valid_ff;
   end

   // ------------------------------------------------------------------
   // Per-packet state.
   // ------------------------------------------------------------------
   tbpcf_pkg::offset_type byte_offset_ff, byte_offset_in;
   logic [3:0]  header_words_ff, header_words_in;
   logic [7:0]  protocol_num_ff, protocol_num_in;
   logic [15:0] total_length_ff, total_length_in;
   logic [3:0]  tcp_header_words_ff, tcp_header_words_in;
   logic [16:0] ip_sum_ff, ip_sum_in;
   logic [16:0] tcp_sum_ff, tcp_sum_in;
   logic        patched_flag_ff, patched_flag_in;
   logic        overflow_ff, overflow_in;

   // Byte handling for the beat at the input.
   logic [7:0]             pkt_byte;
   logic [7:0]             out_byte;
   logic [5:0]             hlen;
   logic [15:0]            word_val;
   logic [16:0]            tcp_sum_mid;
   tbpcf_pkg::offset_type  off;
   tbpcf_pkg::offset_type  hlen_off;
   logic                   bad;
   tbpcf_pkg::verdict_type verdict;

   assign pkt_byte = req_tdata;

   always_comb begin
      off                 = byte_offset_ff;
      out_byte            = pkt_byte;
      header_words_in     = header_words_ff;
      total_length_in     = total_length_ff;
      protocol_num_in     = protocol_num_ff;
      tcp_header_words_in = tcp_header_words_ff;
      ip_sum_in           = ip_sum_ff;
      tcp_sum_in          = tcp_sum_ff;
      tcp_sum_mid         = tcp_sum_ff;
      patched_flag_in     = patched_flag_ff;
      overflow_in         = overflow_ff;
      byte_offset_in      = off;
      hlen                = {header_words_ff, 2'b00};
      hlen_off            = tbpcf_pkg::offset_type'(hlen);
      word_val            = 16'd0;

      if (off < tbpcf_pkg::offset_type'(tbpcf_pkg::MAX_PACKET_BYTES)) begin
         // Header fields come from the original byte, never the patched one.
         if (off == tbpcf_pkg::offset_type'(0)) header_words_in = pkt_byte[3:0];
         if (off == tbpcf_pkg::offset_type'(2)) total_length_in = {pkt_byte, 8'h00};
         if (off == tbpcf_pkg::offset_type'(3))
            total_length_in = total_length_ff | {8'h00, pkt_byte};
         if (off == tbpcf_pkg::offset_type'(tbpcf_pkg::PROTOCOL_OFFSET))
            protocol_num_in = pkt_byte;

         hlen     = {header_words_in, 2'b00};
         hlen_off = tbpcf_pkg::offset_type'(hlen);

         if (patch_enable_ff &&
             off > tbpcf_pkg::offset_type'(tbpcf_pkg::PROTOCOL_OFFSET) &&
             protocol_num_in == tbpcf_pkg::TCP_PROTOCOL &&
             off == tbpcf_pkg::offset_type'(patch_offset_ff)) begin
            out_byte        = patch_value_ff;
            patched_flag_in = 1'b1;
         end

         if (off == hlen_off + tbpcf_pkg::offset_type'(tbpcf_pkg::TCP_DOFF_REL))
            tcp_header_words_in = pkt_byte[7:4];

         // Even offsets are the high byte of a 16-bit word.
         word_val = off[0] ? {8'h00, out_byte} : {out_byte, 8'h00};

         if (off < hlen_off &&
             off != tbpcf_pkg::offset_type'(tbpcf_pkg::IP_CSUM_OFFSET_HI) &&
             off != tbpcf_pkg::offset_type'(tbpcf_pkg::IP_CSUM_OFFSET_LO))
            ip_sum_in = tbpcf_pkg::oc_add(ip_sum_ff, word_val);

         // Source and destination addresses also feed the pseudo-header.
         if (off >= tbpcf_pkg::offset_type'(tbpcf_pkg::PSEUDO_ADDR_FIRST) &&
             off < tbpcf_pkg::offset_type'(tbpcf_pkg::PSEUDO_ADDR_END))
            tcp_sum_mid = tbpcf_pkg::oc_add(tcp_sum_ff, word_val);
         tcp_sum_in = tcp_sum_mid;

         if (off >= hlen_off && 16'(off) < total_length_in &&
             off != hlen_off + tbpcf_pkg::offset_type'(tbpcf_pkg::TCP_CHECK_REL_HI) &&
             off != hlen_off + tbpcf_pkg::offset_type'(tbpcf_pkg::TCP_CHECK_REL_LO))
            tcp_sum_in = tbpcf_pkg::oc_add(tcp_sum_mid, word_val);

         byte_offset_in = off + tbpcf_pkg::offset_type'(1);
      end else begin
         overflow_in = 1'b1;
      end

      // Verdict from the state as it stands after this byte.
      bad = header_words_in < 4'(tbpcf_pkg::MIN_HEADER_WORDS) ||
            tcp_header_words_in < 4'(tbpcf_pkg::MIN_HEADER_WORDS) ||
            total_length_in < (16'(hlen) + 16'({tcp_header_words_in, 2'b00})) ||
            16'(byte_offset_in) < total_length_in ||
            overflow_in;

      if (!req_tlast)
         verdict = tbpcf_pkg::VERDICT_NOT_TCP;
      else if (!patch_enable_ff ||
               byte_offset_in < tbpcf_pkg::offset_type'(tbpcf_pkg::MIN_PACKET_BYTES) ||
               protocol_num_in != tbpcf_pkg::TCP_PROTOCOL)
         verdict = tbpcf_pkg::VERDICT_NOT_TCP;
      else if (bad)
         verdict = tbpcf_pkg::VERDICT_MALFORMED;
      else if (!patched_flag_in)
         verdict = tbpcf_pkg::VERDICT_TOO_SHORT;
      else
         verdict = tbpcf_pkg::VERDICT_REWRITTEN;
   end

   // The state advances on every accepted beat and starts over after a last one.
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff      <= '0;
         header_words_ff     <= '0;
         protocol_num_ff     <= '0;
         total_length_ff     <= '0;
         tcp_header_words_ff <= '0;
         ip_sum_ff           <= '0;
         tcp_sum_ff          <= '0;
         patched_flag_ff     <= 1'b0;
         overflow_ff         <= 1'b0;
      end else if (req_fire) begin
         if (req_tlast) begin
            byte_offset_ff      <= '0;
            header_words_ff     <= '0;
            protocol_num_ff     <= '0;
            total_length_ff     <= '0;
            tcp_header_words_ff <= '0;
            ip_sum_ff           <= '0;
            tcp_sum_ff          <= '0;
            patched_flag_ff     <= 1'b0;
            overflow_ff         <= 1'b0;
         end else begin
            byte_offset_ff      <= byte_offset_in;
            header_words_ff     <= header_words_in;
            protocol_num_ff     <= protocol_num_in;
            total_length_ff     <= total_length_in;
            tcp_header_words_ff <= tcp_header_words_in;
            ip_sum_ff           <= ip_sum_in;
            tcp_sum_ff          <= tcp_sum_in;
            patched_flag_ff     <= patched_flag_in;
            overflow_ff         <= overflow_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // First stage: patched byte, sums after the byte, TCP length, verdict.
   // ------------------------------------------------------------------
   logic [7:0]             s1_byte_ff;
   logic                   s1_last_ff;
   tbpcf_pkg::verdict_type s1_verdict_ff;
   logic [16:0]            s1_ip_sum_ff;
   logic [16:0]            s1_tcp_sum_ff;
   logic [15:0]            s1_tcp_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_fire) begin
         s1_byte_ff    <= out_byte;
         s1_last_ff    <= req_tlast;
         s1_verdict_ff <= verdict;
         s1_ip_sum_ff  <= ip_sum_in;
         s1_tcp_sum_ff <= tcp_sum_in;
         s1_tcp_len_ff <= total_length_in - 16'(hlen);
      end
   end

   // ------------------------------------------------------------------
   // Second stage: pseudo-header protocol and length, final fold, invert.
   // Checksums are reported only for a rewritten packet.
   // ------------------------------------------------------------------
   logic [16:0] tcp_fold_a, tcp_fold_b, tcp_fold_c, ip_fold;
   logic [15:0] tcp_checksum_in, ip_checksum_in;

   always_comb begin
      tcp_fold_a = tbpcf_pkg::oc_add(s1_tcp_sum_ff, 16'(tbpcf_pkg::TCP_PROTOCOL));
      tcp_fold_b = tbpcf_pkg::oc_add(tcp_fold_a, s1_tcp_len_ff);
      tcp_fold_c = tbpcf_pkg::oc_add(tcp_fold_b, 16'd0);
      ip_fold    = tbpcf_pkg::oc_add(s1_ip_sum_ff, 16'd0);
      if (s1_last_ff && s1_verdict_ff == tbpcf_pkg::VERDICT_REWRITTEN) begin
         tcp_checksum_in = ~tcp_fold_c[15:0];
         ip_checksum_in  = ~ip_fold[15:0];
      end else begin
         tcp_checksum_in = 16'd0;
         ip_checksum_in  = 16'd0;
      end
   end

   logic [7:0]             rsp_byte_ff;
   logic                   rsp_last_ff;
   logic [15:0]            rsp_tcp_checksum_ff;
   logic [15:0]            rsp_ip_checksum_ff;
   tbpcf_pkg::verdict_type rsp_verdict_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load && s1_valid_ff) begin
         rsp_byte_ff         <= s1_byte_ff;
         rsp_last_ff         <= s1_last_ff;
         rsp_tcp_checksum_ff <= tcp_checksum_in;
         rsp_ip_checksum_ff  <= ip_checksum_in;
         rsp_verdict_ff      <= s1_verdict_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ip_checksum_ff, rsp_tcp_checksum_ff, rsp_byte_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_verdict_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // A verdict other than not-TCP only ever comes with the last beat.
   a_verdict_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == tbpcf_pkg::VERDICT_NOT_TCP)
      else $error("verdict set on a beat that is not last");

   // Checksums stay zero unless the packet was rewritten.
   a_csum_only_rewritten: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != tbpcf_pkg::VERDICT_REWRITTEN |-> rsp_tdata[39:8] == 32'd0)
      else $error("checksum reported for a packet that was not rewritten");

   // A new packet starts at offset zero with clean sums.
   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> byte_offset_ff == '0 && ip_sum_ff == '0 && tcp_sum_ff == '0)
      else $error("packet state not cleared after the last beat");

   // The output register loads only from a full first stage.
   a_rsp_from_s1: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !s1_valid_ff |=> !rsp_tvalid)
      else $error("result appeared without a beat in the first stage");

endmodule

>>> test/tcp_byte_patch_checksum_fixup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TCP byte patch checksum fixup - self-checking testbench
// Streams IPv4 packets through the fixup block one byte per beat, predicts every
// result beat (patched byte, verdict and fresh checksums) and compares them as
// they leave, under random idling on both sides and several register settings.
// ----------------------------------------------------------------------------
module tcp_byte_patch_checksum_fixup_tb;

   // Header offsets that the package does not name.
   localparam int VER_IHL_OFFSET  = 0;
   localparam int TOTLEN_OFFSET_HI = 2;
   localparam int TOTLEN_OFFSET_LO = 3;

   // Pipeline is two stages deep; the settle wait covers any slack beyond it.
   localparam int SETTLE_CYCLES = 8;
   // Longest legal stretch without any handshake is the long receiver hold-off.
   localparam int LONG_STALL    = 64;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int REPORT_LIMIT  = 20;

   // Packet shapes produced by the stimulus generator.
   typedef enum logic [2:0] {
      PKT_GOOD,
      PKT_OTHER_PROTO,
      PKT_BAD_IHL,
      PKT_BAD_DOFF,
      PKT_LEN_UNDER_HDR,
      PKT_TRUNCATED,
      PKT_NOISE
   } pkt_shape_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } pkt_byte_type;

   typedef struct {
      logic [7:0]             data;
      logic                   last;
      logic [15:0]            tcp_check;
      logic [15:0]            ip_check;
      tbpcf_pkg::verdict_type verdict;
   } fixup_beat_type;

   // DUT ports. Every input has a known value from time zero.
   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [tbpcf_pkg::CSR_ADDR_WIDTH-1:0] csr_addr  = '0;
   logic [tbpcf_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // Packet bytes waiting for the driver, and the patched beats the block owes us.
   pkt_byte_type   send_bytes[$];
   fixup_beat_type due_beats[$];
   pkt_byte_type   next_byte;
   fixup_beat_type want_beat;

   // Traffic shaping, sampled by driver/receiver; the main sequence owns all but the receiver's stall state.
   int unsigned send_idle_pct  = 23;
   int unsigned recv_idle_pct  = 87;
   logic        send_hold      = 1'b0;
   logic        long_stall_go  = 1'b0;
   logic        long_stall_done = 1'b0;
   int unsigned stall_count    = 0;

   // Shadow copy of the patch registers.
   logic [10:0] cfg_offset = tbpcf_pkg::PATCH_OFFSET_RESET;
   logic [7:0]  cfg_value  = tbpcf_pkg::PATCH_VALUE_RESET;
   logic        cfg_enable = tbpcf_pkg::PATCH_ENABLE_RESET;

   // Per-packet parse and sum state of the prediction, cleared after every last beat.
   logic [11:0] sum_offset   = '0;
   logic [3:0]  ihl_words    = '0;
   logic [3:0]  doff_words   = '0;
   logic [7:0]  proto_num    = '0;
   logic [15:0] tot_len      = '0;
   logic [16:0] ip_acc       = '0;
   logic [16:0] tcp_acc      = '0;
   logic        patched_seen = 1'b0;
   logic        overrun_seen = 1'b0;

   // Bookkeeping for the summary.
   int unsigned mismatches   = 0;
   int unsigned beats_in     = 0;
   int unsigned beats_out    = 0;
   int unsigned bytes_queued = 0;
   int unsigned packets_seen = 0;
   int unsigned csr_writes   = 0;
   int unsigned verdict_seen[4] = '{0, 0, 0, 0};

   tcp_byte_patch_checksum_fixup dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // End-around-carry add of one 16-bit word into a 17-bit running sum.
   function automatic logic [16:0] fold_add(input logic [16:0] acc, input logic [15:0] word);
      logic [17:0] wide;
      wide = {1'b0, acc} + {2'b00, word};
      fold_add = {1'b0, wide[15:0]} + {15'd0, wide[17:16]};
   endfunction

   // Works out the result beat for one accepted packet byte and advances the
   // per-packet state. Fields are parsed from the original byte, while the sums
   // see the byte as it leaves the block, patched or not.
   function automatic fixup_beat_type patch_and_sum(input logic [7:0] in_byte,
                                                    input logic in_last);
      fixup_beat_type res;
      int unsigned off;
      int unsigned hlen;
      int unsigned seen;
      logic [7:0]  ob;
      logic [15:0] word;
      logic [16:0] acc;
      logic        bad;
      res  = '{data: in_byte, last: in_last, tcp_check: '0, ip_check: '0,
               verdict: tbpcf_pkg::VERDICT_NOT_TCP};
      ob   = in_byte;
      off  = int'(sum_offset);
      if (off < tbpcf_pkg::MAX_PACKET_BYTES) begin
         if (off == VER_IHL_OFFSET)   ihl_words = in_byte[3:0];
         if (off == TOTLEN_OFFSET_HI) tot_len   = {in_byte, 8'h00};
         if (off == TOTLEN_OFFSET_LO) tot_len[7:0] = in_byte;
         if (off == tbpcf_pkg::PROTOCOL_OFFSET) proto_num = in_byte;
         hlen = int'(ihl_words) * 4;
         // Only a TCP packet whose protocol byte has already gone by gets patched.
         if (cfg_enable && off > tbpcf_pkg::PROTOCOL_OFFSET &&
             proto_num == tbpcf_pkg::TCP_PROTOCOL && off == cfg_offset) begin
            ob = cfg_value;
            patched_seen = 1'b1;
         end
         if (off == hlen + tbpcf_pkg::TCP_DOFF_REL) doff_words = in_byte[7:4];
         word = off[0] ? {8'h00, ob} : {ob, 8'h00};
         if (off < hlen && off != tbpcf_pkg::IP_CSUM_OFFSET_HI &&
             off != tbpcf_pkg::IP_CSUM_OFFSET_LO)
            ip_acc = fold_add(ip_acc, word);
         // Source and destination addresses belong to the pseudo-header.
         if (off >= tbpcf_pkg::PSEUDO_ADDR_FIRST && off < tbpcf_pkg::PSEUDO_ADDR_END)
            tcp_acc = fold_add(tcp_acc, word);
         if (off >= hlen && off < tot_len && off != hlen + tbpcf_pkg::TCP_CHECK_REL_HI &&
             off != hlen + tbpcf_pkg::TCP_CHECK_REL_LO)
            tcp_acc = fold_add(tcp_acc, word);
         sum_offset = 12'(off + 1);
      end else begin
         // Bytes past the maximum pass untouched and only spoil the packet.
         overrun_seen = 1'b1;
      end
      res.data = ob;

      if (in_last) begin
         hlen = int'(ihl_words) * 4;
         seen = int'(sum_offset);
         bad  = ihl_words < tbpcf_pkg::MIN_HEADER_WORDS ||
                doff_words < tbpcf_pkg::MIN_HEADER_WORDS ||
                tot_len < hlen + doff_words * 4 || seen < tot_len || overrun_seen;
         if (!cfg_enable || seen < tbpcf_pkg::MIN_PACKET_BYTES ||
             proto_num != tbpcf_pkg::TCP_PROTOCOL)
            res.verdict = tbpcf_pkg::VERDICT_NOT_TCP;
         else if (bad)
            res.verdict = tbpcf_pkg::VERDICT_MALFORMED;
         else if (!patched_seen)
            res.verdict = tbpcf_pkg::VERDICT_TOO_SHORT;
         else
            res.verdict = tbpcf_pkg::VERDICT_REWRITTEN;
         if (res.verdict == tbpcf_pkg::VERDICT_REWRITTEN) begin
            // Pseudo-header: protocol and TCP length; the addresses are already in.
            acc = fold_add(tcp_acc, {8'h00, tbpcf_pkg::TCP_PROTOCOL});
            acc = fold_add(acc, tot_len - 16'(hlen));
            acc = fold_add(acc, 16'h0000);
            res.tcp_check = ~acc[15:0];
            acc = fold_add(ip_acc, 16'h0000);
            res.ip_check = ~acc[15:0];
         end
         verdict_seen[res.verdict]++;
         packets_seen++;
         sum_offset   = '0;
         ihl_words    = '0;
         doff_words   = '0;
         proto_num    = '0;
         tot_len      = '0;
         ip_acc       = '0;
         tcp_acc      = '0;
         patched_seen = 1'b0;
         overrun_seen = 1'b0;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("MISMATCH result beat %0d: %s got 0x%0h, want 0x%0h",
                  beats_out, what, got, want);
   endtask

   task automatic push_byte(input logic [7:0] data, input logic last);
      send_bytes.push_back('{data: data, last: last});
      bytes_queued++;
   endtask

   // Builds one packet of the given shape. A nonzero len_hint sets total_length and
   // the byte count where header size and shape allow; otherwise lengths cluster around the
   // patch offset so that both the rewritten and the too-short outcomes come up often.
   task automatic queue_packet(input pkt_shape_type shape, input int unsigned len_hint);
      logic [7:0]  pkt[$];
      logic [7:0]  proto;
      int unsigned ihl;
      int unsigned doff;
      int unsigned hdr_bytes;
      int unsigned tot;
      int unsigned count;
      int unsigned i;
      ihl  = ($urandom_range(1) == 0) ? tbpcf_pkg::MIN_HEADER_WORDS :
             $urandom_range(15, tbpcf_pkg::MIN_HEADER_WORDS);
      doff = ($urandom_range(1) == 0) ? tbpcf_pkg::MIN_HEADER_WORDS :
             $urandom_range(15, tbpcf_pkg::MIN_HEADER_WORDS);
      if (shape == PKT_BAD_IHL)  ihl  = $urandom_range(tbpcf_pkg::MIN_HEADER_WORDS - 1);
      if (shape == PKT_BAD_DOFF) doff = $urandom_range(tbpcf_pkg::MIN_HEADER_WORDS - 1);
      hdr_bytes = (ihl + doff) * 4;

      if (len_hint != 0)
         tot = len_hint;
      else if ($urandom_range(99) < 65)
         tot = cfg_offset + $urandom_range(24, 1);
      else
         tot = hdr_bytes + $urandom_range(40);
      if (tot < hdr_bytes) tot = hdr_bytes;
      if (tot > tbpcf_pkg::MAX_PACKET_BYTES) tot = tbpcf_pkg::MAX_PACKET_BYTES;
      count = tot;
      // Some packets carry trailing padding beyond total_length.
      if (len_hint == 0 && $urandom_range(3) == 0) count = tot + $urandom_range(4, 1);
      if (count > tbpcf_pkg::MAX_PACKET_BYTES) count = tbpcf_pkg::MAX_PACKET_BYTES;

      case (shape)
         PKT_LEN_UNDER_HDR: begin
            tot   = $urandom_range(hdr_bytes - 1);
            count = hdr_bytes + $urandom_range(20);
         end
         PKT_TRUNCATED: count = $urandom_range(tot - 1, 1);
         PKT_NOISE: count = $urandom_range(80, 1);
         default: ;
      endcase

      proto = tbpcf_pkg::TCP_PROTOCOL;
      if (shape == PKT_OTHER_PROTO) begin
         do proto = 8'($urandom_range(255)); while (proto == tbpcf_pkg::TCP_PROTOCOL);
      end

      for (i = 0; i < count; i++) pkt.push_back(8'($urandom_range(255)));
      if (shape != PKT_NOISE) begin
         pkt[VER_IHL_OFFSET] = {4'h4, ihl[3:0]};
         if (count > TOTLEN_OFFSET_LO) begin
            pkt[TOTLEN_OFFSET_HI] = tot[15:8];
            pkt[TOTLEN_OFFSET_LO] = tot[7:0];
         end
         if (count > tbpcf_pkg::PROTOCOL_OFFSET) pkt[tbpcf_pkg::PROTOCOL_OFFSET] = proto;
         if (ihl * 4 + tbpcf_pkg::TCP_DOFF_REL < count)
            pkt[ihl * 4 + tbpcf_pkg::TCP_DOFF_REL] = {doff[3:0], 4'($urandom_range(15))};
      end
      for (i = 0; i < count; i++) push_byte(pkt[i], i == count - 1);
   endtask

   // Mostly well-formed TCP with random content, the rest other protocols,
   // broken headers, truncations and plain noise.
   task automatic queue_random_traffic(input int unsigned budget);
      int unsigned start;
      int unsigned pick;
      start = bytes_queued;
      while (bytes_queued - start < budget) begin
         pick = $urandom_range(99);
         if (pick < 60)      queue_packet(PKT_GOOD, 0);
         else if (pick < 70) queue_packet(PKT_OTHER_PROTO, 0);
         else if (pick < 75) queue_packet(PKT_BAD_IHL, 0);
         else if (pick < 80) queue_packet(PKT_BAD_DOFF, 0);
         else if (pick < 85) queue_packet(PKT_LEN_UNDER_HDR, 0);
         else if (pick < 90) queue_packet(PKT_TRUNCATED, 0);
         else                queue_packet(PKT_NOISE, 0);
      end
   endtask

   // Registers are only touched while the block is idle, so the shadow copy is
   // updated right at the accepting edge.
   task automatic write_csr(input logic [tbpcf_pkg::CSR_ADDR_WIDTH-1:0] index,
                            input logic [tbpcf_pkg::CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         tbpcf_pkg::CSR_PATCH_OFFSET: cfg_offset = data[10:0];
         tbpcf_pkg::CSR_PATCH_VALUE:  cfg_value  = data[7:0];
         tbpcf_pkg::CSR_PATCH_ENABLE: cfg_enable = data[0];
         default: ;
      endcase
      csr_writes++;
   endtask

   // Waits until every queued byte has gone in and every result beat has come out.
   task automatic wait_drained();
      while (send_bytes.size() != 0 || req_tvalid || due_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Driver: loads the next byte once the current beat is taken or none is up.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (send_bytes.size() != 0 && !send_hold &&
             $urandom_range(99) >= send_idle_pct) begin
            next_byte = send_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_byte.data;
            req_tlast  <= next_byte.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off on request that
   // lets the pipeline fill and push back on the input side.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_stall_go && !long_stall_done) begin
         rsp_tready <= 1'b0;
         if (stall_count == LONG_STALL - 1) long_stall_done <= 1'b1;
         stall_count <= stall_count + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Monitor: predicts on every accepted input beat and checks every accepted
   // result beat against the oldest prediction. Input is handled first so a result
   // leaving in the same cycle as its input beat would still line up.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            due_beats.push_back(patch_and_sum(req_tdata, req_tlast));
            beats_in++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (due_beats.size() == 0) begin
               report_mismatch("unexpected beat, data", rsp_tdata[31:0], 32'd0);
            end else begin
               want_beat = due_beats.pop_front();
               if (rsp_tdata[7:0] != want_beat.data)
                  report_mismatch("out_byte", 32'(rsp_tdata[7:0]), 32'(want_beat.data));
               if (rsp_tlast != want_beat.last)
                  report_mismatch("out_last", 32'(rsp_tlast), 32'(want_beat.last));
               if (rsp_tdata[23:8] != want_beat.tcp_check)
                  report_mismatch("tcp_checksum", 32'(rsp_tdata[23:8]),
                                  32'(want_beat.tcp_check));
               if (rsp_tdata[39:24] != want_beat.ip_check)
                  report_mismatch("ip_checksum", 32'(rsp_tdata[39:24]),
                                  32'(want_beat.ip_check));
               if (rsp_tuser != want_beat.verdict)
                  report_mismatch("verdict", 32'(rsp_tuser), 32'(want_beat.verdict));
            end
            beats_out++;
         end
      end
   end

   // Watchdog: any handshake restarts the count; a stuck block ends the run.
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout after %0d quiet cycles, %0d results outstanding",
               WATCHDOG_LIMIT, due_beats.size());
      $display("Regression FAIL");
      $finish;
   end

   // Main sequence.
   initial begin
      int unsigned i;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset settings (offset 63, value 0x21, enabled). A one-byte packet, a
      // packet that ends just before the protocol byte, and one that ends right
      // on a TCP protocol byte with no TCP header, which must come out malformed.
      push_byte(8'hFF, 1'b1);
      for (i = 0; i < tbpcf_pkg::PROTOCOL_OFFSET; i++)
         push_byte(i[0] ? 8'hFF : 8'h00, i == tbpcf_pkg::PROTOCOL_OFFSET - 1);
      for (i = 0; i <= tbpcf_pkg::PROTOCOL_OFFSET; i++) begin
         if (i == VER_IHL_OFFSET)
            push_byte(8'h45, 1'b0);
         else if (i == tbpcf_pkg::PROTOCOL_OFFSET)
            push_byte(tbpcf_pkg::TCP_PROTOCOL, 1'b1);
         else
            push_byte(8'(i * 29), 1'b0);
      end
      queue_random_traffic(350);
      wait_drained();

      // Offset 60 and a zero patch byte. With a 44-byte IP header the patch
      // lands on the TCP checksum field, with 60 bytes on the source port.
      write_csr(tbpcf_pkg::CSR_PATCH_OFFSET, 11'd60);
      write_csr(tbpcf_pkg::CSR_PATCH_VALUE, 11'd0);
      queue_random_traffic(350);
      wait_drained();

      // Sender now idles most of the time. Highest offset: short packets never
      // reach it, so a whole one comes out too short.
      send_idle_pct <= 87;
      recv_idle_pct <= 23;
      write_csr(tbpcf_pkg::CSR_PATCH_OFFSET, 11'd2047);
      write_csr(tbpcf_pkg::CSR_PATCH_VALUE, 11'd255);
      queue_packet(PKT_GOOD, 100);
      queue_packet(PKT_TRUNCATED, 100);
      wait_drained();

      // Patching disabled: everything passes unchanged with a not-TCP verdict.
      write_csr(tbpcf_pkg::CSR_PATCH_ENABLE, 11'd0);
      write_csr(tbpcf_pkg::CSR_PATCH_OFFSET, 11'd64);
      queue_random_traffic(250);
      wait_drained();

      // Full rate on both sides, with the long receiver hold-off and one sender
      // pause in the middle of the stream.
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
      write_csr(tbpcf_pkg::CSR_PATCH_ENABLE, 11'd1);
      write_csr(tbpcf_pkg::CSR_PATCH_OFFSET, 11'd72);
      write_csr(tbpcf_pkg::CSR_PATCH_VALUE, 11'($urandom_range(255)));
      queue_random_traffic(450);
      @(posedge clock);
      long_stall_go <= 1'b1;
      while (!long_stall_done) @(posedge clock);
      while (send_bytes.size() > 250) @(posedge clock);
      send_hold <= 1'b1;
      @(posedge clock);
      while (req_tvalid || due_beats.size() != 0) @(posedge clock);
      send_hold <= 1'b0;
      wait_drained();

      if (due_beats.size() != 0)
         report_mismatch("results never delivered", 32'(due_beats.size()), 32'd0);
      $display("Covered %0d beats in %0d packets over %0d register writes, one %0d-cycle hold-off",
               beats_in, packets_seen, csr_writes, LONG_STALL);
      $display("Verdicts: rewritten %0d, too short %0d, not TCP %0d, malformed %0d; %0d mismatches",
               verdict_seen[tbpcf_pkg::VERDICT_REWRITTEN],
               verdict_seen[tbpcf_pkg::VERDICT_TOO_SHORT],
               verdict_seen[tbpcf_pkg::VERDICT_NOT_TCP],
               verdict_seen[tbpcf_pkg::VERDICT_MALFORMED], mismatches);
      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
